>>> rtl/core/stpseq_pkg.sv
// ----------------------------------------------------------------------------
// stpseq_pkg
// Shared types, opcodes and coil tables for the stepper coil sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package stpseq_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int DELAY_WIDTH_DEF = 16;

    // opcodes; code 3 behaves as a tick
    localparam logic [1:0] OP_TICK        = 2'd0;
    localparam logic [1:0] OP_START_COUNT = 2'd1;
    localparam logic [1:0] OP_START_ANGLE = 2'd2;
    localparam logic [1:0] OP_SPARE       = 2'd3;

    // register byte addresses
    localparam logic [2:0] ADDR_MODE  = 3'd0;
    localparam logic [2:0] ADDR_DELAY = 3'd4;

    localparam logic       MODE_RESET  = 1'b1;
    localparam logic [15:0] DELAY_RESET = 16'd2;

    // ceil(2^21 * 64 / 45): angle * ANGLE_RECIP >> 21 == floor(angle * 64 / 45)
    localparam logic [21:0] ANGLE_RECIP = 22'd2982617;

    localparam logic [3:0] HALF_TAB [8] = '{4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};
    localparam logic [3:0] FULL_TAB [4] = '{4'h8, 4'h4, 4'h2, 4'h1};

    typedef struct packed {
        logic        half_step_mode;
        logic [15:0] delay_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] cycle_count;
        logic [14:0] angle_deg;
        logic        forward;
    } item_t;

    typedef struct packed {
        logic [3:0] coils;
        logic       busy_res;
        logic       done_res;
        logic       rejected;
    } result_t;

    // pattern at a table position; position clamps to the current table's end
    function automatic logic [3:0] pattern_at(input logic mode, input logic fwd,
                                              input logic [2:0] pos);
        logic [2:0] last;
        logic [2:0] p;
        logic [2:0] idx;
        last = mode ? 3'd7 : 3'd3;
        p    = (pos > last) ? last : pos;
        idx  = fwd ? p : 3'(last - p);
        return mode ? HALF_TAB[idx] : FULL_TAB[idx[1:0]];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/stpseq_regs.sv
// ----------------------------------------------------------------------------
// stpseq_regs
// APB configuration registers: step mode and per-pattern hold time.
// ----------------------------------------------------------------------------
`default_nettype none

module stpseq_regs (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output stpseq_pkg::cfg_t        cfg
);
    import stpseq_pkg::*;

    logic        mode_reg;
    logic [15:0] delay_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_RESET;
            delay_reg <= DELAY_RESET;
        end else if (wr_en) begin
            if (paddr == ADDR_MODE) begin
                mode_reg <= pwdata[0];
            end
            if (paddr == ADDR_DELAY) begin
                delay_reg <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_MODE) begin
            prdata = {31'd0, mode_reg};
        end else if (paddr == ADDR_DELAY) begin
            prdata = {16'd0, delay_reg};
        end
    end

    assign cfg.half_step_mode = mode_reg;
    assign cfg.delay_ticks    = delay_reg;

endmodule

`default_nettype wire

>>> rtl/core/stpseq_angle.sv
// ----------------------------------------------------------------------------
// stpseq_angle
// Angle to cycle count: floor(angle * 64 / 45) by reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module stpseq_angle (
    input  wire logic [14:0] angle_deg,
    output logic [15:0]      cycles
);
    import stpseq_pkg::*;

    logic [36:0] prod;

    // exact for all 15-bit angles: rounding error of the reciprocal stays below 1/45
    assign prod   = 37'(angle_deg) * 37'(ANGLE_RECIP);
    assign cycles = prod[36:21];

endmodule

`default_nettype wire

>>> rtl/core/stpseq_core.sv
// ----------------------------------------------------------------------------
// stpseq_core
// Sequencer state and next-state logic; updated once per processed word.
// ----------------------------------------------------------------------------
`default_nettype none

module stpseq_core #(
    parameter int COUNT_WIDTH = stpseq_pkg::COUNT_WIDTH_DEF,
    parameter int DELAY_WIDTH = stpseq_pkg::DELAY_WIDTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step_en,
    input  stpseq_pkg::item_t       item,
    input  wire logic [15:0]        angle_cycles,
    input  stpseq_pkg::cfg_t        cfg,
    output stpseq_pkg::result_t     result
);
    import stpseq_pkg::*;

    localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);
    localparam logic [31:0] DLY_MAX = 32'((64'd1 << DELAY_WIDTH) - 64'd1);
    localparam logic [DELAY_WIDTH-1:0] HOLD_ONE = DELAY_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);

    logic                   running_reg, running_next;
    logic [2:0]             pos_reg, pos_next;
    logic [DELAY_WIDTH-1:0] hold_reg, hold_next;
    logic [COUNT_WIDTH-1:0] cycles_reg, cycles_next;
    logic                   dir_reg, dir_next;
    logic [3:0]             coil_reg, coil_next;

    logic                   is_start;
    logic [15:0]            cnt_raw;
    logic [31:0]            cnt_wide;
    logic [COUNT_WIDTH-1:0] cnt_sat;
    logic [31:0]            dly_wide;
    logic [DELAY_WIDTH-1:0] dly_load;
    logic                   wrap;
    logic [COUNT_WIDTH-1:0] cycles_dec;
    logic [2:0]             pos_adv;
    logic                   done;
    logic                   rej;

    assign is_start = (item.op == OP_START_COUNT) || (item.op == OP_START_ANGLE);
    assign cnt_raw  = (item.op == OP_START_COUNT) ? item.cycle_count : angle_cycles;
    assign cnt_wide = 32'(cnt_raw);
    assign cnt_sat  = (cnt_wide > CNT_MAX) ? CNT_MAX[COUNT_WIDTH-1:0]
                                           : cnt_wide[COUNT_WIDTH-1:0];

    // zero delay holds for one tick
    assign dly_wide = (cfg.delay_ticks == 16'd0) ? 32'd1 : 32'(cfg.delay_ticks);
    assign dly_load = (dly_wide > DLY_MAX) ? DLY_MAX[DELAY_WIDTH-1:0]
                                           : dly_wide[DELAY_WIDTH-1:0];

    // table is read live, so a mode switch mid-move can end a cycle early
    assign wrap       = ({1'b0, pos_reg} + 4'd1) >= (cfg.half_step_mode ? 4'd8 : 4'd4);
    assign cycles_dec = wrap ? (cycles_reg - CNT_ONE) : cycles_reg;
    assign pos_adv    = wrap ? 3'd0 : 3'(pos_reg + 3'd1);

    always_comb begin
        running_next = running_reg;
        pos_next     = pos_reg;
        hold_next    = hold_reg;
        cycles_next  = cycles_reg;
        dir_next     = dir_reg;
        coil_next    = coil_reg;
        done         = 1'b0;
        rej          = 1'b0;
        priority if (is_start) begin
            if (running_reg) begin
                rej = 1'b1;
            end else if (cnt_sat == '0) begin
                coil_next = 4'd0;
            end else begin
                running_next = 1'b1;
                dir_next     = item.forward;
                cycles_next  = cnt_sat;
                pos_next     = 3'd0;
                coil_next    = pattern_at(cfg.half_step_mode, item.forward, 3'd0);
                hold_next    = dly_load;
            end
        end else if (running_reg) begin
            if (hold_reg > HOLD_ONE) begin
                hold_next = hold_reg - HOLD_ONE;
            end else begin
                cycles_next = cycles_dec;
                if (cycles_dec == '0) begin
                    running_next = 1'b0;
                    pos_next     = 3'd0;
                    hold_next    = '0;
                    coil_next    = 4'd0;
                    done         = 1'b1;
                end else begin
                    pos_next  = pos_adv;
                    coil_next = pattern_at(cfg.half_step_mode, dir_reg, pos_adv);
                    hold_next = dly_load;
                end
            end
        end else begin
            // tick while idle: nothing moves
            running_next = running_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            pos_reg     <= 3'd0;
            hold_reg    <= '0;
            cycles_reg  <= '0;
            dir_reg     <= 1'b1;
            coil_reg    <= 4'd0;
        end else if (step_en) begin
            running_reg <= running_next;
            pos_reg     <= pos_next;
            hold_reg    <= hold_next;
            cycles_reg  <= cycles_next;
            dir_reg     <= dir_next;
            coil_reg    <= coil_next;
        end
    end

    assign result.coils    = coil_next;
    assign result.busy_res = running_next;
    assign result.done_res = done;
    assign result.rejected = rej;

endmodule

`default_nettype wire

>>> rtl/core/stepper_coil_sequencer.sv
// ----------------------------------------------------------------------------
// stepper_coil_sequencer
// Four-coil stepper sequencer: half-step or single-coil tables, moves by
// cycle count or angle, one result word per command or tick word.
// ----------------------------------------------------------------------------
//  channel  | ports                                        | dir
//  ---------+----------------------------------------------+-----
//  input    | s_valid s_ready s_op s_cycle_count           | in
//           | s_angle_deg s_forward                        |
//  result   | m_valid m_ready m_coils m_busy_res           | out
//           | m_done_res m_rejected                        |
//  config   | psel penable pwrite paddr pwdata prdata pready | APB
//
//  From input accept to result valid a word passes the input register, then the
//  sequencer step (angle multiply and counter update) into the result register.
//  One word per cycle sustained; s_ready drops only when both registers are full
//  and m_ready is low.
//  Synchronous active-low reset; coils off, not busy, mode half-step, delay 2.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_coil_sequencer #(
    parameter int COUNT_WIDTH = stpseq_pkg::COUNT_WIDTH_DEF,
    parameter int DELAY_WIDTH = stpseq_pkg::DELAY_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_op,
    input  wire logic [15:0] s_cycle_count,
    input  wire logic [14:0] s_angle_deg,
    input  wire logic        s_forward,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_coils,
    output logic             m_busy_res,
    output logic             m_done_res,
    output logic             m_rejected,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import stpseq_pkg::*;

    cfg_t        cfg;
    item_t       in_item_reg;
    logic        in_valid_reg;
    result_t     res_reg;
    result_t     res_next;
    logic        m_valid_reg;
    logic        step_en;
    logic [15:0] angle_cycles;

    stpseq_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    stpseq_angle u_angle (
        .angle_deg (in_item_reg.angle_deg),
        .cycles    (angle_cycles)
    );

    stpseq_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .item         (in_item_reg),
        .angle_cycles (angle_cycles),
        .cfg          (cfg),
        .result       (res_next)
    );

    assign step_en = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.op          <= s_op;
            in_item_reg.cycle_count <= s_cycle_count;
            in_item_reg.angle_deg   <= s_angle_deg;
            in_item_reg.forward     <= s_forward;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            res_reg <= res_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_coils    = res_reg.coils;
    assign m_busy_res = res_reg.busy_res;
    assign m_done_res = res_reg.done_res;
    assign m_rejected = res_reg.rejected;

    // a finished move leaves the coils off and the sequencer idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res && (m_coils == 4'd0))
        else $error("done without idle coils");

    // a start can only be refused while a move is under way
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rejected |-> m_busy_res && !m_done_res)
        else $error("reject while idle");

    // input stalls only when both stages are full and the sink is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled with room");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stepper_coil_sequencer. Tick and move words flow
// through a valid/ready driver; a clocked monitor compares every result word
// against an in-bench model of the coil sequencer. Config goes through APB
// between phases: reset values first, then both tables and a range of hold
// delays, ending with the longest hold and the largest angle at full rate.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stpseq_pkg::*;

    // table entry i sits at nibble i
    localparam logic [31:0] HALF_PATTERNS = 32'h9132_64C8;
    localparam logic [15:0] FULL_PATTERNS = 16'h1248;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] count;
        logic [14:0] angle;
        logic        fwd;
    } move_word_t;

    typedef struct packed {
        logic [3:0] coils;
        logic       busy;
        logic       done;
        logic       rejected;
    } coil_word_t;

    typedef struct packed {
        logic        running;
        logic [2:0]  pos;
        logic [15:0] hold;
        logic [15:0] cycles;
        logic        fwd;
        logic [3:0]  coils;
    } seq_state_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op = OP_TICK;
    logic [15:0] s_cycle_count = '0;
    logic [14:0] s_angle_deg = '0;
    logic        s_forward = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_coils;
    logic        m_busy_res;
    logic        m_done_res;
    logic        m_rejected;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        cfg_half = MODE_RESET;
    logic [15:0] cfg_delay = DELAY_RESET;

    seq_state_t  live_st;   // advanced on each accepted word
    seq_state_t  plan_st;   // advanced as words are queued, steers the generator

    move_word_t  words_to_send[$];
    coil_word_t  coil_words_due[$];
    move_word_t  next_word;
    int          idle_pct = 0;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          fail_cnt = 0;

    always #1 aclk = ~aclk;

    stepper_coil_sequencer DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_cycle_count (s_cycle_count),
        .s_angle_deg   (s_angle_deg),
        .s_forward     (s_forward),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_coils       (m_coils),
        .m_busy_res    (m_busy_res),
        .m_done_res    (m_done_res),
        .m_rejected    (m_rejected),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    function automatic logic [3:0] coil_pattern(input int pos, input logic fwd);
        int len;
        int p;
        int idx;
        len = cfg_half ? 8 : 4;
        p   = (pos >= len) ? len - 1 : pos;
        idx = fwd ? p : len - 1 - p;
        return cfg_half ? HALF_PATTERNS[idx*4 +: 4] : FULL_PATTERNS[idx*4 +: 4];
    endfunction

    function automatic logic [15:0] hold_reload();
        return (cfg_delay == 16'd0) ? 16'd1 : cfg_delay;
    endfunction

    function automatic coil_word_t step_coils(inout seq_state_t st, input move_word_t w);
        coil_word_t r;
        int cnt;
        int len;
        int nxt;
        r   = '0;
        len = cfg_half ? 8 : 4;
        if (w.op == OP_START_COUNT || w.op == OP_START_ANGLE) begin
            if (st.running) begin
                r.rejected = 1'b1;
            end else begin
                cnt = (w.op == OP_START_COUNT) ? int'(w.count) : (int'(w.angle) * 64) / 45;
                if (cnt > 65535)
                    cnt = 65535;
                if (cnt == 0) begin
                    st.coils = 4'd0;
                end else begin
                    st.running = 1'b1;
                    st.fwd     = w.fwd;
                    st.cycles  = 16'(cnt);
                    st.pos     = 3'd0;
                    st.coils   = coil_pattern(0, w.fwd);
                    st.hold    = hold_reload();
                end
            end
        end else if (st.running) begin
            // spare opcode counts as a tick
            if (st.hold > 16'd1) begin
                st.hold = st.hold - 16'd1;
            end else begin
                nxt = (int'(st.pos) + 1) & 7;
                if (int'(st.pos) + 1 >= len) begin
                    st.cycles = st.cycles - 16'd1;
                    nxt = 0;
                end
                if (st.cycles == 16'd0) begin
                    st.running = 1'b0;
                    st.pos     = 3'd0;
                    st.hold    = 16'd0;
                    st.coils   = 4'd0;
                    r.done     = 1'b1;
                end else begin
                    st.pos   = 3'(nxt);
                    st.coils = coil_pattern(nxt, st.fwd);
                    st.hold  = hold_reload();
                end
            end
        end
        r.coils = st.coils;
        r.busy  = st.running;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [3:0] expv,
                               input logic [3:0] actv);
        if (expv !== actv) begin
            $error("%s: expected %h, got %h", name, expv, actv);
            fail_cnt++;
        end
    endtask

    // driver: predicts on accept, then reloads or idles
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                coil_words_due.push_back(step_coils(live_st,
                    move_word_t'({s_op, s_cycle_count, s_angle_deg, s_forward})));
            if (!s_valid || s_ready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                    src_gap = $urandom_range(0, 17);
                    s_valid <= 1'b0;
                end else if (words_to_send.size() != 0) begin
                    next_word = words_to_send.pop_front();
                    s_valid       <= 1'b1;
                    s_op          <= next_word.op;
                    s_cycle_count <= next_word.count;
                    s_angle_deg   <= next_word.angle;
                    s_forward     <= next_word.fwd;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (coil_words_due.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_cnt++;
                end else begin
                    check_field("coils", coil_words_due[0].coils, m_coils);
                    check_field("busy_res", {3'd0, coil_words_due[0].busy},
                                {3'd0, m_busy_res});
                    check_field("done_res", {3'd0, coil_words_due[0].done},
                                {3'd0, m_done_res});
                    check_field("rejected", {3'd0, coil_words_due[0].rejected},
                                {3'd0, m_rejected});
                    void'(coil_words_due.pop_front());
                end
            end
            if (sink_gap != 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                sink_gap = $urandom_range(0, 17);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic move_word_t rand_word(input logic [1:0] op);
        move_word_t w;
        w.op    = op;
        w.count = 16'($urandom());
        w.angle = 15'($urandom());
        w.fwd   = 1'($urandom());
        return w;
    endfunction

    function automatic move_word_t mk_word(input logic [1:0] op, input logic [15:0] count,
                                           input logic [14:0] angle, input logic fwd);
        move_word_t w;
        w.op    = op;
        w.count = count;
        w.angle = angle;
        w.fwd   = fwd;
        return w;
    endfunction

    task automatic plan_word(input move_word_t w);
        void'(step_coils(plan_st, w));
        words_to_send.push_back(w);
    endtask

    task automatic fill_random(input int n);
        move_word_t w;
        repeat (n) begin
            if (plan_st.running) begin
                if ($urandom_range(0, 9) == 0)
                    w = rand_word($urandom_range(0, 1) ? OP_START_COUNT : OP_START_ANGLE);
                else
                    w = rand_word($urandom_range(0, 7) == 0 ? OP_SPARE : OP_TICK);
            end else if ($urandom_range(0, 5) == 0) begin
                w = rand_word($urandom_range(0, 1) ? OP_SPARE : OP_TICK);
            end else begin
                // short move so it finishes within the phase most of the time
                w = rand_word($urandom_range(0, 1) ? OP_START_COUNT : OP_START_ANGLE);
                w.count = 16'($urandom_range(0, 3));
                w.angle = 15'($urandom_range(0, 4));
            end
            plan_word(w);
        end
    endtask

    task automatic finish_move();
        while (plan_st.running)
            plan_word(rand_word(OP_TICK));
    endtask

    // wait until every queued word is through and its result checked
    task automatic settle();
        while (words_to_send.size() != 0 || s_valid || coil_words_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        plan_st = live_st;
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic mode, input logic [15:0] delay);
        logic [31:0] junk;
        junk = $urandom();
        apb_write(ADDR_MODE, {junk[31:1], mode});
        cfg_half = mode;
        junk = $urandom();
        apb_write(ADDR_DELAY, {junk[31:16], delay});
        cfg_delay = delay;
    endtask

    initial begin
        logic        mode;
        logic [15:0] dly;
        int          pct;
        live_st     = '0;
        live_st.fwd = 1'b1;
        plan_st     = live_st;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset config: idle ticks, a one-cycle move with a
        // rejected start, zero counts, then an angle move left running
        plan_word(mk_word(OP_TICK, 16'd0, 15'd0, 1'b0));
        plan_word(mk_word(OP_SPARE, 16'hFFFF, 15'h7FFF, 1'b1));
        plan_word(mk_word(OP_START_COUNT, 16'd1, 15'd0, 1'b1));
        plan_word(mk_word(OP_START_ANGLE, 16'hFFFF, 15'h7FFF, 1'b0));
        repeat (15) plan_word(mk_word(OP_TICK, 16'd0, 15'd0, 1'b0));
        plan_word(mk_word(OP_SPARE, 16'd0, 15'd0, 1'b0));
        plan_word(mk_word(OP_START_COUNT, 16'd0, 15'h7FFF, 1'b1));
        plan_word(mk_word(OP_START_ANGLE, 16'hFFFF, 15'd0, 1'b1));
        plan_word(mk_word(OP_START_ANGLE, 16'd0, 15'd1, 1'b0));
        repeat (2) plan_word(mk_word(OP_TICK, 16'd0, 15'd0, 1'b0));

        // random phases; a move may span a config change
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    mode = 1'b0; dly = 16'd1; pct = 25;
                end
                1: begin
                    mode = 1'b1; dly = 16'd0; pct = 40;
                end
                2: begin
                    mode = 1'b0; dly = 16'd3; pct = 0;
                end
                3: begin
                    mode = 1'b1; dly = 16'd1; pct = 15;
                end
                default: begin
                    mode = 1'($urandom_range(0, 1));
                    dly  = 16'($urandom_range(1, 4));
                    pct  = $urandom_range(0, 40);
                end
            endcase
            settle();
            set_config(mode, dly);
            idle_pct = pct;
            fill_random(150);
        end

        // full rate from here on: largest angle, then the longest hold
        settle();
        idle_pct = 0;
        finish_move();
        settle();
        set_config(1'b0, 16'd1);
        plan_word(mk_word(OP_START_ANGLE, 16'd0, 15'h7FFF, 1'b0));
        repeat (20) plan_word(rand_word(OP_TICK));
        settle();
        set_config(1'b0, 16'hFFFF);   // applies from the next pattern load
        repeat (8) plan_word(rand_word(OP_TICK));
        settle();

        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
